// ----- src/dwpi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes of the dual-wheel incremental PI speed controller.
package dwpi_pkg;

   localparam int CMD_W        = 16;
   localparam int GAIN_W       = 16;
   localparam int SAMPLE_W     = 16;
   localparam int SCALE_W      = 8;
   localparam int DRIVE_W      = 32;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int TARGET_LIMIT = 20;
   localparam int ACCUM_WIDTH  = 24;

   // Target is the command sum before clamping, error is target minus sample.
   localparam int TGT_W  = CMD_W + 1;
   localparam int ERR_W  = TGT_W + 1;
   localparam int DIFF_W = ERR_W + 1;
   // The partial product high word holds the sum of two addends and its negation.
   localparam int HI_W   = DIFF_W + 3;
   localparam int PROD_W = HI_W + GAIN_W;
   localparam int TOT_W  = ((PROD_W > (ACCUM_WIDTH + 8)) ? PROD_W : (ACCUM_WIDTH + 8)) + 1;
   localparam int CNT_W  = $clog2(GAIN_W);

   // Cycles from an accepted item to its result when the output register is free.
   localparam int LATENCY = GAIN_W + SCALE_W + 4;

   localparam logic [CSR_IDX_W-1:0] REG_VELOCITY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TURN        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_PROP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_INT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_PROP  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_INT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_SCALE = 3'd6;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_speed_sample;
      logic signed [SAMPLE_W-1:0] right_speed_sample;
   } req_data_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_ADD,
      ST_SAT,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic mul_last;
      logic add;
      logic sat;
      logic smul;
      logic out_load;
   } ctl_type;

endpackage

// ----- src/dwpi_lane.sv -----
`timescale 1ns / 1ps
// One wheel: error, bit-serial PI update of the accumulator and bit-serial drive scaling.
module dwpi_lane import dwpi_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_type                    ctl,
   input  logic signed [TGT_W-1:0]    target,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [GAIN_W-1:0]   prop_gain,
   input  logic signed [GAIN_W-1:0]   int_gain,
   input  logic [SCALE_W-1:0]         scale,
   output logic signed [DRIVE_W-1:0]  drive
);

   localparam int QW    = TOT_W - 8;
   localparam int SHI_W = ACCUM_WIDTH + 1;
   localparam int SPR_W = SHI_W + SCALE_W;
   localparam int SAT_W = ((SPR_W > DRIVE_W) ? SPR_W : DRIVE_W) + 1;
   localparam logic signed [QW-1:0] Q_MAX = QW'((64'd1 << (ACCUM_WIDTH - 1)) - 64'd1);
   localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);
   localparam logic signed [SAT_W-1:0] D_MAX = SAT_W'((64'd1 << (DRIVE_W - 1)) - 64'd1);
   localparam logic signed [SAT_W-1:0] D_MIN = -D_MAX - SAT_W'(1);

   logic signed [ERR_W-1:0]       prev_ff, prev_in;
   logic signed [ACCUM_WIDTH-1:0] accum_ff, accum_in;
   logic signed [ERR_W-1:0]       err_ff, err_in;
   logic signed [DIFF_W-1:0]      diff_ff, diff_in;
   logic [GAIN_W-1:0]             pg_ff, pg_in;
   logic [GAIN_W-1:0]             ig_ff, ig_in;
   logic signed [HI_W-1:0]        hi_ff, hi_in;
   logic [GAIN_W-1:0]             lo_ff, lo_in;
   logic signed [TOT_W-1:0]       total_ff, total_in;
   logic [SCALE_W-1:0]            sc_ff, sc_in;
   logic signed [SHI_W-1:0]       shi_ff, shi_in;
   logic [SCALE_W-1:0]            slo_ff, slo_in;
   logic signed [SAT_W-1:0]       sprod;

   always_comb begin
      logic signed [HI_W-1:0]  addend;
      logic signed [HI_W-1:0]  nh;
      logic signed [QW-1:0]    quot;
      logic signed [SHI_W-1:0] saddend;
      logic signed [SHI_W-1:0] ns;

      prev_in  = prev_ff;
      accum_in = accum_ff;
      err_in   = err_ff;
      diff_in  = diff_ff;
      pg_in    = pg_ff;
      ig_in    = ig_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      total_in = total_ff;
      sc_in    = sc_ff;
      shi_in   = shi_ff;
      slo_in   = slo_ff;

      addend = (pg_ff[0] ? HI_W'(diff_ff) : '0) + (ig_ff[0] ? HI_W'(err_ff) : '0);
      // The top gain bit carries negative weight.
      if (ctl.mul_last) begin
         addend = -addend;
      end
      nh = hi_ff + addend;

      quot = QW'(total_ff >>> 8);
      // Division by 256 rounds toward zero, so a negative value with a fraction moves up.
      if (total_ff[TOT_W-1] && (total_ff[7:0] != 8'd0)) begin
         quot = quot + QW'(1);
      end

      saddend = sc_ff[0] ? SHI_W'(accum_ff) : '0;
      ns      = shi_ff + saddend;

      if (ctl.load) begin
         err_in = ERR_W'(target) - ERR_W'(sample);
         pg_in  = prop_gain;
         ig_in  = int_gain;
      end
      if (ctl.prep) begin
         diff_in = DIFF_W'(err_ff) - DIFF_W'(prev_ff);
         prev_in = err_ff;
         hi_in   = '0;
         lo_in   = '0;
      end
      if (ctl.mul) begin
         hi_in = nh >>> 1;
         lo_in = {nh[0], lo_ff[GAIN_W-1:1]};
         pg_in = pg_ff >> 1;
         ig_in = ig_ff >> 1;
      end
      if (ctl.add) begin
         total_in = TOT_W'($signed({hi_ff, lo_ff})) + (TOT_W'(accum_ff) <<< 8);
      end
      if (ctl.sat) begin
         if (quot > Q_MAX) begin
            accum_in = ACCUM_WIDTH'(Q_MAX);
         end else if (quot < Q_MIN) begin
            accum_in = ACCUM_WIDTH'(Q_MIN);
         end else begin
            accum_in = ACCUM_WIDTH'(quot);
         end
         shi_in = '0;
         sc_in  = scale;
      end
      if (ctl.smul) begin
         shi_in = ns >>> 1;
         slo_in = {ns[0], slo_ff[SCALE_W-1:1]};
         sc_in  = sc_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         accum_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         accum_ff <= accum_in;
      end
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      pg_ff    <= pg_in;
      ig_ff    <= ig_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      total_ff <= total_in;
      sc_ff    <= sc_in;
      shi_ff   <= shi_in;
      slo_ff   <= slo_in;
   end

   always_comb begin
      sprod = SAT_W'($signed({shi_ff, slo_ff}));
      if (sprod > D_MAX) begin
         drive = DRIVE_W'(D_MAX);
      end else if (sprod < D_MIN) begin
         drive = DRIVE_W'(D_MIN);
      end else begin
         drive = DRIVE_W'(sprod);
      end
   end

endmodule

// ----- src/dwpi_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer that steps both wheel lanes through one update and owns the result handshake.
module dwpi_ctrl import dwpi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: state_in = ST_SAT;
         ST_SAT: state_in = ST_SCALE;
         ST_SCALE: begin
            if (cnt_ff == CNT_W'(SCALE_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl          = '0;
      req_ready    = (state_ff == ST_IDLE);
      ctl.load     = (state_ff == ST_IDLE) && req_valid;
      ctl.prep     = (state_ff == ST_PREP);
      ctl.mul      = (state_ff == ST_MUL);
      ctl.mul_last = (state_ff == ST_MUL) && (cnt_ff == CNT_W'(GAIN_W - 1));
      ctl.add      = (state_ff == ST_ADD);
      ctl.sat      = (state_ff == ST_SAT);
      ctl.smul     = (state_ff == ST_SCALE);
      ctl.out_load = (state_ff == ST_DONE) && out_free;
      cnt_in       = ((state_ff == ST_MUL) || (state_ff == ST_SCALE)) ? cnt_ff + CNT_W'(1) : '0;
      rsp_valid_in = ctl.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/dual_wheel_incremental_pi_speed.sv -----
`timescale 1ns / 1ps
// Each update runs the 16 gain-bit steps of the shift-add PI multiplier and then the 8
// scale-bit steps of the drive multiplier, both lanes running in parallel; a held result
// register stalls the sequencer before the result is loaded. One item is in work at a time.
// The result register lets the next item enter while the previous result waits.
// Synchronous reset clears commands and gains to zero, drive scale to one, and the previous
// errors and accumulators to zero.
module dual_wheel_incremental_pi_speed import dwpi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [TGT_W-1:0] TGT_MAX = TGT_W'(TARGET_LIMIT);
   localparam logic signed [TGT_W-1:0] TGT_MIN = -TGT_MAX;

   logic signed [CMD_W-1:0]  velocity_ff, velocity_in;
   logic signed [CMD_W-1:0]  turn_ff, turn_in;
   logic signed [GAIN_W-1:0] left_prop_ff, left_prop_in;
   logic signed [GAIN_W-1:0] left_int_ff, left_int_in;
   logic signed [GAIN_W-1:0] right_prop_ff, right_prop_in;
   logic signed [GAIN_W-1:0] right_int_ff, right_int_in;
   logic [SCALE_W-1:0]       scale_ff, scale_in;
   rsp_data_type             rsp_data_ff, rsp_data_in;

   logic signed [TGT_W-1:0]   left_sum, right_sum;
   logic signed [TGT_W-1:0]   left_target, right_target;
   logic signed [DRIVE_W-1:0] left_drive, right_drive;
   ctl_type                   ctl;

   assign csr_ready = 1'b1;

   always_comb begin
      velocity_in   = velocity_ff;
      turn_in       = turn_ff;
      left_prop_in  = left_prop_ff;
      left_int_in   = left_int_ff;
      right_prop_in = right_prop_ff;
      right_int_in  = right_int_ff;
      scale_in      = scale_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_VELOCITY:    velocity_in   = CMD_W'(csr_wdata);
            REG_TURN:        turn_in       = CMD_W'(csr_wdata);
            REG_LEFT_PROP:   left_prop_in  = GAIN_W'(csr_wdata);
            REG_LEFT_INT:    left_int_in   = GAIN_W'(csr_wdata);
            REG_RIGHT_PROP:  right_prop_in = GAIN_W'(csr_wdata);
            REG_RIGHT_INT:   right_int_in  = GAIN_W'(csr_wdata);
            REG_DRIVE_SCALE: scale_in      = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_ff   <= '0;
         turn_ff       <= '0;
         left_prop_ff  <= '0;
         left_int_ff   <= '0;
         right_prop_ff <= '0;
         right_int_ff  <= '0;
         scale_ff      <= SCALE_W'(1);
      end else begin
         velocity_ff   <= velocity_in;
         turn_ff       <= turn_in;
         left_prop_ff  <= left_prop_in;
         left_int_ff   <= left_int_in;
         right_prop_ff <= right_prop_in;
         right_int_ff  <= right_int_in;
         scale_ff      <= scale_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      left_sum  = TGT_W'(velocity_ff) + TGT_W'(turn_ff);
      right_sum = TGT_W'(velocity_ff) - TGT_W'(turn_ff);
      if (left_sum > TGT_MAX) begin
         left_target = TGT_MAX;
      end else if (left_sum < TGT_MIN) begin
         left_target = TGT_MIN;
      end else begin
         left_target = left_sum;
      end
      if (right_sum > TGT_MAX) begin
         right_target = TGT_MAX;
      end else if (right_sum < TGT_MIN) begin
         right_target = TGT_MIN;
      end else begin
         right_target = right_sum;
      end
   end

   dwpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   dwpi_lane u_left (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .target    (left_target),
      .sample    (req_data.left_speed_sample),
      .prop_gain (left_prop_ff),
      .int_gain  (left_int_ff),
      .scale     (scale_ff),
      .drive     (left_drive)
   );

   dwpi_lane u_right (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .target    (right_target),
      .sample    (req_data.right_speed_sample),
      .prop_gain (right_prop_ff),
      .int_gain  (right_int_ff),
      .scale     (scale_ff),
      .drive     (right_drive)
   );

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (ctl.out_load) begin
         rsp_data_in.left_drive  = left_drive;
         rsp_data_in.right_drive = right_drive;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ----- src/dwpi_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the speed controller and its bind to the top level.
module dwpi_checker import dwpi_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_data_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // A result that is not taken stays offered with the same payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

   // A fresh result must come from an item accepted earlier by the update latency and the result register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, LATENCY + 1))
      else $error("result appeared without a matching item");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dual_wheel_incremental_pi_speed dwpi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
